@@ hw/rtl/imucf_pkg.sv @@
package imucf_pkg;

   // one raw sensor sample
   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
   } req_type;

   // one filtered attitude result
   typedef struct packed {
      logic [15:0] roll_centideg;
      logic [15:0] pitch_centideg;
      logic [15:0] yaw_centideg;
   } rsp_type;

   // configuration register values
   typedef struct packed {
      logic [15:0] blend_alpha_q15;
      logic [15:0] gyro_step_gain;
   } cfg_type;

   // request to the cordic unit: raw vector, scaled inside
   typedef struct packed {
      logic               start;
      logic signed [17:0] y;
      logic signed [17:0] x;
   } cordic_req_type;

   // cordic result, one turn is 2^32
   typedef struct packed {
      logic        done;
      logic [31:0] z;
   } cordic_rsp_type;

   // register indexes
   localparam logic [1:0] CSR_ALPHA = 2'd0;
   localparam logic [1:0] CSR_GAIN  = 2'd1;

   localparam logic [15:0] ALPHA_ONE   = 16'd32768;
   localparam logic [15:0] ALPHA_RESET = 16'd32113;
   localparam logic [15:0] GAIN_RESET  = 16'd910;
   localparam int          ATAN_LEN    = 24;

   // atan(2^-i) with one turn = 2^32
   function automatic logic [31:0] atan_turn32(input logic [4:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10680862;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/imucf_req_queue.sv @@
module imucf_req_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  imucf_pkg::req_type push_item,
   output logic              full,
   input  logic              pop,
   output imucf_pkg::req_type head,
   output logic              empty
);
   import imucf_pkg::*;

   req_type     mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/imucf_cordic.sv @@
module imucf_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  imucf_pkg::cordic_req_type req,
   output imucf_pkg::cordic_rsp_type rsp
);
   import imucf_pkg::*;

   localparam int N  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int CW = $clog2(N);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [43:0] x_ff, x_in;
   logic signed [43:0] y_ff, y_in;
   logic [31:0]        z_ff, z_in;
   logic [CW-1:0]      step_ff, step_in;

   logic signed [43:0] xs, ys, dx, dy;
   logic [31:0]        ang;

   assign xs  = 44'(req.x) <<< 24;
   assign ys  = 44'(req.y) <<< 24;
   assign dx  = y_ff >>> step_ff;
   assign dy  = x_ff >>> step_ff;
   assign ang = atan_turn32(5'(step_ff));

   assign rsp.done = done_ff;
   assign rsp.z    = z_ff;

   // pre-rotation on start, then one micro-rotation per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (req.start) begin
            step_in = '0;
            if (req.x == 18'sd0 && req.y == 18'sd0) begin
               z_in    = 32'd0;
               done_in = 1'b1;
            end else begin
               busy_in = 1'b1;
               if (req.x < 0) begin
                  if (req.y >= 0) begin
                     x_in = ys;
                     y_in = -xs;
                     z_in = 32'h4000_0000;
                  end else begin
                     x_in = -ys;
                     y_in = xs;
                     z_in = 32'hC000_0000;
                  end
               end else begin
                  x_in = xs;
                  y_in = ys;
                  z_in = 32'd0;
               end
            end
         end
      end else begin
         if (y_ff >= 0) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == CW'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
   end

endmodule

@@ hw/rtl/imucf_engine.sv @@
module imucf_engine #(
   parameter int CORDIC_STEPS        = 16,
   parameter int ANGLE_FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  imucf_pkg::cfg_type cfg,
   input  imucf_pkg::req_type head,
   input  logic               head_empty,
   output logic               head_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output imucf_pkg::rsp_type rsp_item
);
   import imucf_pkg::*;

   localparam int F  = ANGLE_FRACTION_BITS;
   localparam int PW = F + 17;

   localparam logic [4:0] ST_IDLE       = 5'd0;
   localparam logic [4:0] ST_SQ_Y       = 5'd1;
   localparam logic [4:0] ST_SQ_Z       = 5'd2;
   localparam logic [4:0] ST_SQRT       = 5'd3;
   localparam logic [4:0] ST_ROLL_GO    = 5'd4;
   localparam logic [4:0] ST_ROLL_WAIT  = 5'd5;
   localparam logic [4:0] ST_PITCH_GO   = 5'd6;
   localparam logic [4:0] ST_PITCH_WAIT = 5'd7;
   localparam logic [4:0] ST_PROP_R     = 5'd8;
   localparam logic [4:0] ST_PROP_P     = 5'd9;
   localparam logic [4:0] ST_PROP_Y     = 5'd10;
   localparam logic [4:0] ST_BLEND_R    = 5'd11;
   localparam logic [4:0] ST_BLEND_P    = 5'd12;
   localparam logic [4:0] ST_CD_R       = 5'd13;
   localparam logic [4:0] ST_CD_P       = 5'd14;
   localparam logic [4:0] ST_CD_Y       = 5'd15;
   localparam logic [4:0] ST_OUT        = 5'd16;

   logic [4:0]   state_ff, state_in;
   req_type      item_ff, item_in;
   logic [31:0]  v_ff, v_in;
   logic [31:0]  r_ff, r_in;
   logic [3:0]   k_ff, k_in;
   logic [F-1:0] meas_r_ff, meas_r_in;
   logic [F-1:0] meas_p_ff, meas_p_in;
   logic [F-1:0] prop_r_ff, prop_r_in;
   logic [F-1:0] prop_p_ff, prop_p_in;
   logic [F-1:0] roll_ff, roll_in;
   logic [F-1:0] pitch_ff, pitch_in;
   logic [F-1:0] yaw_ff, yaw_in;
   logic [15:0]  cd_r_ff, cd_r_in;
   logic [15:0]  cd_p_ff, cd_p_in;
   logic [15:0]  cd_y_ff, cd_y_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   cordic_req_type creq;
   cordic_rsp_type crsp;

   imucf_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .req  (creq),
      .rsp  (crsp)
   );

   // squaring multiplier
   logic signed [15:0] sq_op;
   logic signed [31:0] sq_prod;
   assign sq_op   = (state_ff == ST_SQ_Y) ? item_ff.accel_y : item_ff.accel_z;
   assign sq_prod = sq_op * sq_op;

   // square root digit step
   logic [31:0] bitv, rb;
   assign bitv = 32'd1 << (5'd30 - {k_ff, 1'b0});
   assign rb   = r_ff + bitv;

   // cordic angle rounded to the binary angle width
   logic [31:0]  z_round;
   logic [F-1:0] z_meas;
   assign z_round = crsp.z + (32'd1 << (31 - F));
   assign z_meas  = z_round[31 -: F];

   // gyro propagation multiplier
   logic [F-1:0]       pg_angle;
   logic signed [15:0] pg_rate;
   logic signed [32:0] pg_prod;
   logic [F-1:0]       pg_new;
   always_comb begin
      case (state_ff)
         ST_PROP_R: begin
            pg_angle = roll_ff;
            pg_rate  = item_ff.gyro_x;
         end
         ST_PROP_P: begin
            pg_angle = pitch_ff;
            pg_rate  = item_ff.gyro_y;
         end
         default: begin
            pg_angle = yaw_ff;
            pg_rate  = item_ff.gyro_z;
         end
      endcase
   end
   assign pg_prod = pg_rate * $signed({1'b0, cfg.gyro_step_gain});
   assign pg_new  = pg_angle + pg_prod[F-1:0];

   // blend on the wrapped difference
   logic [15:0]          alpha_sat, w;
   logic [F-1:0]         bl_prop, bl_meas, bl_diff, bl_new;
   logic signed [PW-1:0] bl_prod, bl_sum, bl_corr;
   assign alpha_sat = (cfg.blend_alpha_q15 > ALPHA_ONE) ? ALPHA_ONE : cfg.blend_alpha_q15;
   assign w         = ALPHA_ONE - alpha_sat;
   assign bl_prop   = (state_ff == ST_BLEND_R) ? prop_r_ff : prop_p_ff;
   assign bl_meas   = (state_ff == ST_BLEND_R) ? meas_r_ff : meas_p_ff;
   assign bl_diff   = bl_meas - bl_prop;
   assign bl_prod   = $signed(bl_diff) * $signed({1'b0, w});
   assign bl_sum    = bl_prod + $signed(PW'(16384));
   assign bl_corr   = bl_sum >>> 15;
   assign bl_new    = bl_prop + bl_corr[F-1:0];

   // centidegree conversion
   logic [F-1:0]  cd_src;
   logic [PW-1:0] cd_sum;
   logic [16:0]   cd_raw;
   logic [15:0]   cd_val;
   always_comb begin
      case (state_ff)
         ST_CD_R: cd_src = roll_ff;
         ST_CD_P: cd_src = pitch_ff;
         default: cd_src = yaw_ff;
      endcase
   end
   assign cd_sum = PW'(cd_src) * PW'(36000) + (PW'(1) << (F - 1));
   assign cd_raw = cd_sum[F +: 17];
   assign cd_val = (cd_raw >= 17'd36000) ? 16'd0 : cd_raw[15:0];

   assign head_pop  = (state_ff == ST_IDLE) && !head_empty;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      v_in         = v_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      meas_r_in    = meas_r_ff;
      meas_p_in    = meas_p_ff;
      prop_r_in    = prop_r_ff;
      prop_p_in    = prop_p_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      yaw_in       = yaw_ff;
      cd_r_in      = cd_r_ff;
      cd_p_in      = cd_p_ff;
      cd_y_in      = cd_y_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      creq.start   = 1'b0;
      creq.y       = 18'(item_ff.accel_y);
      creq.x       = 18'(item_ff.accel_z);
      unique case (state_ff)
         ST_IDLE: begin
            if (!head_empty) begin
               item_in  = head;
               state_in = ST_SQ_Y;
            end
         end
         ST_SQ_Y: begin
            v_in     = $unsigned(sq_prod);
            state_in = ST_SQ_Z;
         end
         ST_SQ_Z: begin
            v_in     = v_ff + $unsigned(sq_prod);
            r_in     = 32'd0;
            k_in     = 4'd0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (v_ff >= rb) begin
               v_in = v_ff - rb;
               r_in = (r_ff >> 1) + bitv;
            end else begin
               r_in = r_ff >> 1;
            end
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd15) begin
               state_in = ST_ROLL_GO;
            end
         end
         ST_ROLL_GO: begin
            creq.start = 1'b1;
            state_in   = ST_ROLL_WAIT;
         end
         ST_ROLL_WAIT: begin
            if (crsp.done) begin
               meas_r_in = z_meas;
               state_in  = ST_PITCH_GO;
            end
         end
         ST_PITCH_GO: begin
            creq.start = 1'b1;
            creq.y     = 18'sd0 - 18'(item_ff.accel_x);
            creq.x     = {2'b00, r_ff[15:0]};
            state_in   = ST_PITCH_WAIT;
         end
         ST_PITCH_WAIT: begin
            if (crsp.done) begin
               meas_p_in = z_meas;
               state_in  = ST_PROP_R;
            end
         end
         ST_PROP_R: begin
            prop_r_in = pg_new;
            state_in  = ST_PROP_P;
         end
         ST_PROP_P: begin
            prop_p_in = pg_new;
            state_in  = ST_PROP_Y;
         end
         ST_PROP_Y: begin
            yaw_in   = pg_new;
            state_in = ST_BLEND_R;
         end
         ST_BLEND_R: begin
            roll_in  = bl_new;
            state_in = ST_BLEND_P;
         end
         ST_BLEND_P: begin
            pitch_in = bl_new;
            state_in = ST_CD_R;
         end
         ST_CD_R: begin
            cd_r_in  = cd_val;
            state_in = ST_CD_P;
         end
         ST_CD_P: begin
            cd_p_in  = cd_val;
            state_in = ST_CD_Y;
         end
         ST_CD_Y: begin
            cd_y_in  = cd_val;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_in.roll_centideg  = cd_r_ff;
               rsp_in.pitch_centideg = cd_p_ff;
               rsp_in.yaw_centideg   = cd_y_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      v_ff      <= v_in;
      r_ff      <= r_in;
      k_ff      <= k_in;
      meas_r_ff <= meas_r_in;
      meas_p_ff <= meas_p_in;
      prop_r_ff <= prop_r_in;
      prop_p_ff <= prop_p_in;
      cd_r_ff   <= cd_r_in;
      cd_p_ff   <= cd_p_in;
      cd_y_ff   <= cd_y_in;
      rsp_ff    <= rsp_in;
   end

endmodule

@@ hw/rtl/imu_complementary_attitude_filter.sv @@
// processing time is set by the 16-step square root and two passes of the shared iterative
// cordic, and is shorter when an accelerometer vector is zero
// samples are processed one at a time; a two-entry input queue and a
// result register let either side stall on its own
// reset: synchronous, clears angles to zero and sets alpha 32113, gain 910
module imu_complementary_attitude_filter #(
   parameter int CORDIC_STEPS        = 16,
   parameter int ANGLE_FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  imucf_pkg::req_type req_item,
   output logic               req_full,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output imucf_pkg::rsp_type rsp_item,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import imucf_pkg::*;

   cfg_type cfg_ff, cfg_in;
   req_type head;
   logic    head_empty, head_pop;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ALPHA: cfg_in.blend_alpha_q15 = csr_wdata;
            CSR_GAIN:  cfg_in.gyro_step_gain  = csr_wdata;
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_alpha_q15 <= ALPHA_RESET;
         cfg_ff.gyro_step_gain  <= GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: sample queue
   imucf_req_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_item(req_item),
      .full     (req_full),
      .pop      (head_pop),
      .head     (head),
      .empty    (head_empty)
   );

   // back: filter engine
   imucf_engine #(
      .CORDIC_STEPS       (CORDIC_STEPS),
      .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .head_empty(head_empty),
      .head_pop  (head_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
